// ----- src/aesbc_pkg.sv -----
// Shared types, constants and round functions for the AES block cipher unit.
package aesbc_pkg;

   localparam logic [3:0] NR_128        = 4'd10;
   localparam logic [3:0] NR_256        = 4'd14;
   localparam logic [5:0] LAST_WORD_128 = 6'd43;
   localparam logic [5:0] LAST_WORD_256 = 6'd59;

   typedef enum logic [1:0] {
      ST_EXPAND,
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      REG_KEY_IS_256 = 3'd0,
      REG_KEY_WORD_0 = 3'd1,
      REG_KEY_WORD_1 = 3'd2,
      REG_KEY_WORD_2 = 3'd3,
      REG_KEY_WORD_3 = 3'd4
   } reg_idx_type;

   typedef struct packed {
      logic       load;
      logic       round;
      logic       last;
      logic       decrypt;
      logic [3:0] key_addr;
      logic       exp_we;
      logic [5:0] exp_idx;
   } cmd_type;

   typedef struct packed {
      logic key_is_256;
   } status_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // linear part of the inverse affine map
   function automatic logic [7:0] inv_affine_lin(input logic [7:0] v);
      return {v[6:0], v[7]} ^ {v[4:0], v[7:5]} ^ {v[1:0], v[7:2]};
   endfunction

   // inverse S-box through the forward table: inv = L(S(L(s)^05))^05
   function automatic logic [7:0] inv_sbox(input logic [7:0] s);
      logic [7:0] t;
      t = inv_affine_lin(s) ^ 8'h05;
      return inv_affine_lin(SBOX[t]) ^ 8'h05;
   endfunction

   function automatic logic [127:0] shift_rows(input logic [127:0] s);
      logic [127:0] t;
      t = '0;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            t[8*(r+4*c) +: 8] = s[8*(r+4*((c+r)%4)) +: 8];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] inv_shift_rows(input logic [127:0] s);
      logic [127:0] t;
      t = '0;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            t[8*(r+4*((c+r)%4)) +: 8] = s[8*(r+4*c) +: 8];
         end
      end
      return t;
   endfunction

   function automatic logic [31:0] mix_col(input logic [31:0] col);
      logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3;
      a0 = col[7:0];   a1 = col[15:8];
      a2 = col[23:16]; a3 = col[31:24];
      b0 = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      b1 = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      b2 = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      b3 = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      return {b3, b2, b1, b0};
   endfunction

   function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
      logic [7:0] a [4];
      logic [7:0] m9 [4];
      logic [7:0] m11 [4];
      logic [7:0] m13 [4];
      logic [7:0] m14 [4];
      logic [7:0] x2, x4, x8;
      for (int i = 0; i < 4; i++) begin
         a[i]   = col[8*i +: 8];
         x2     = xtime(a[i]);
         x4     = xtime(x2);
         x8     = xtime(x4);
         m9[i]  = x8 ^ a[i];
         m11[i] = x8 ^ x2 ^ a[i];
         m13[i] = x8 ^ x4 ^ a[i];
         m14[i] = x8 ^ x4 ^ x2;
      end
      return {m11[0] ^ m13[1] ^ m9[2]  ^ m14[3],
              m13[0] ^ m9[1]  ^ m14[2] ^ m11[3],
              m9[0]  ^ m14[1] ^ m11[2] ^ m13[3],
              m14[0] ^ m11[1] ^ m13[2] ^ m9[3]};
   endfunction

endpackage

// ----- src/aesbc_if.sv -----
// Item channel interfaces: block request in, cipher result out.
interface aesbc_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [63:0] data_low;
   logic [63:0] data_high;

   modport source(output valid, action, data_low, data_high, input ready);
   modport sink(input valid, action, data_low, data_high, output ready);
endinterface

interface aesbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_low;
   logic [63:0] result_high;

   modport source(output valid, result_low, result_high, input ready);
   modport sink(input valid, result_low, result_high, output ready);
endinterface

// ----- src/aesbc_ctrl.sv -----
// Sequencer: key expansion walk, round counting and item handshakes.
module aesbc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cfg_write,
   input  logic                    req_valid,
   input  logic                    req_action,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  aesbc_pkg::status_type   status,
   output aesbc_pkg::cmd_type      cmd
);

   aesbc_pkg::state_type state_ff, state_in;
   logic [3:0]           rnd_ff, rnd_in;
   logic [5:0]           wcnt_ff, wcnt_in;
   logic                 dec_ff, dec_in;
   logic [3:0]           nr;
   logic [5:0]           last_word;

   assign nr        = status.key_is_256 ? aesbc_pkg::NR_256 : aesbc_pkg::NR_128;
   assign last_word = status.key_is_256 ? aesbc_pkg::LAST_WORD_256
                                        : aesbc_pkg::LAST_WORD_128;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aesbc_pkg::ST_EXPAND;
         rnd_ff   <= '0;
         wcnt_ff  <= '0;
         dec_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         wcnt_ff  <= wcnt_in;
         dec_ff   <= dec_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      rnd_in    = rnd_ff;
      wcnt_in   = wcnt_ff;
      dec_in    = dec_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      cmd.decrypt  = dec_ff;
      cmd.key_addr = rnd_ff;
      cmd.exp_idx  = wcnt_ff;
      case (state_ff)
         aesbc_pkg::ST_EXPAND: begin
            cmd.exp_we = 1'b1;
            if (wcnt_ff == last_word) begin
               state_in = aesbc_pkg::ST_IDLE;
            end else begin
               wcnt_in = wcnt_ff + 6'd1;
            end
         end
         aesbc_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.key_addr = req_action ? nr : 4'd0;
            if (req_valid) begin
               cmd.load = 1'b1;
               dec_in   = req_action;
               rnd_in   = req_action ? nr - 4'd1 : 4'd1;
               state_in = aesbc_pkg::ST_RUN;
            end
         end
         aesbc_pkg::ST_RUN: begin
            cmd.round = 1'b1;
            cmd.last  = dec_ff ? (rnd_ff == 4'd0) : (rnd_ff == nr);
            if (cmd.last) begin
               state_in = aesbc_pkg::ST_DONE;
            end else begin
               rnd_in = dec_ff ? rnd_ff - 4'd1 : rnd_ff + 4'd1;
            end
         end
         aesbc_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = aesbc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = aesbc_pkg::ST_EXPAND;
            wcnt_in  = '0;
         end
      endcase
      // any key register write restarts the expansion
      if (cfg_write) begin
         state_in = aesbc_pkg::ST_EXPAND;
         wcnt_in  = '0;
      end
   end

endmodule

// ----- src/aesbc_dp.sv -----
// Datapath: key registers, key schedule, round key store and round unit.
module aesbc_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr,
   input  logic [2:0]            csr_idx,
   input  logic [63:0]           csr_wdata,
   output logic [63:0]           csr_rdata,
   input  aesbc_pkg::cmd_type    cmd,
   output aesbc_pkg::status_type status,
   input  logic [63:0]           data_low,
   input  logic [63:0]           data_high,
   output logic [63:0]           result_low,
   output logic [63:0]           result_high
);

   logic              k256_ff;
   logic [63:0]       kw_ff [4];
   logic [255:0]      key_all;

   logic [7:0][31:0]  win_ff;
   logic [7:0]        rcon_ff, rcon_in;
   logic [127:0]      rk_ff [15];
   logic [127:0]      rk;
   logic [31:0]       w_new, t_prev, t_rot, t_sub, w_back;
   logic              past_nk, rot_step, sub_step;

   logic [127:0]      s_ff, s_in;
   logic [127:0]      shifted, subbed, keyed, mixed;

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         k256_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            kw_ff[i] <= '0;
         end
      end else if (csr_wr) begin
         case (aesbc_pkg::reg_idx_type'(csr_idx))
            aesbc_pkg::REG_KEY_IS_256: k256_ff  <= csr_wdata[0];
            aesbc_pkg::REG_KEY_WORD_0: kw_ff[0] <= csr_wdata;
            aesbc_pkg::REG_KEY_WORD_1: kw_ff[1] <= csr_wdata;
            aesbc_pkg::REG_KEY_WORD_2: kw_ff[2] <= csr_wdata;
            aesbc_pkg::REG_KEY_WORD_3: kw_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (aesbc_pkg::reg_idx_type'(csr_idx))
         aesbc_pkg::REG_KEY_IS_256: csr_rdata = {63'd0, k256_ff};
         aesbc_pkg::REG_KEY_WORD_0: csr_rdata = kw_ff[0];
         aesbc_pkg::REG_KEY_WORD_1: csr_rdata = kw_ff[1];
         aesbc_pkg::REG_KEY_WORD_2: csr_rdata = kw_ff[2];
         aesbc_pkg::REG_KEY_WORD_3: csr_rdata = kw_ff[3];
         default:                   csr_rdata = '0;
      endcase
   end

   assign status.key_is_256 = k256_ff;
   assign key_all = {kw_ff[3], kw_ff[2], kw_ff[1], kw_ff[0]};

   // key schedule, one 32-bit word per cycle; win_ff[0] is the newest word
   assign past_nk  = k256_ff ? (cmd.exp_idx >= 6'd8) : (cmd.exp_idx >= 6'd4);
   assign rot_step = k256_ff ? (cmd.exp_idx[2:0] == 3'd0) : (cmd.exp_idx[1:0] == 2'd0);
   assign sub_step = k256_ff && (cmd.exp_idx[2:0] == 3'd4);
   assign t_prev   = win_ff[0];
   assign t_rot    = rot_step ? {t_prev[7:0], t_prev[31:8]} : t_prev;
   assign w_back   = k256_ff ? win_ff[7] : win_ff[3];

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         t_sub[8*j +: 8] = aesbc_pkg::SBOX[t_rot[8*j +: 8]];
      end
      rcon_in = rcon_ff;
      if (cmd.exp_idx == 6'd0) begin
         rcon_in = 8'h01;
      end else if (past_nk && rot_step) begin
         rcon_in = aesbc_pkg::xtime(rcon_ff);
      end
      if (!past_nk) begin
         w_new = key_all[32*cmd.exp_idx[2:0] +: 32];
      end else if (rot_step) begin
         w_new = w_back ^ t_sub ^ {24'd0, rcon_ff};
      end else if (sub_step) begin
         w_new = w_back ^ t_sub;
      end else begin
         w_new = w_back ^ t_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exp_we) begin
         win_ff  <= {win_ff[6:0], w_new};
         rcon_ff <= rcon_in;
         rk_ff[cmd.exp_idx[5:2]][32*cmd.exp_idx[1:0] +: 32] <= w_new;
      end
   end

   assign rk = rk_ff[cmd.key_addr];

   // round unit; decryption adds the raw key before InvMixColumns
   always_comb begin
      shifted = cmd.decrypt ? aesbc_pkg::inv_shift_rows(s_ff) : aesbc_pkg::shift_rows(s_ff);
      for (int b = 0; b < 16; b++) begin
         subbed[8*b +: 8] = cmd.decrypt ? aesbc_pkg::inv_sbox(shifted[8*b +: 8])
                                        : aesbc_pkg::SBOX[shifted[8*b +: 8]];
      end
      keyed = subbed ^ rk;
      for (int c = 0; c < 4; c++) begin
         mixed[32*c +: 32] = cmd.decrypt ? aesbc_pkg::inv_mix_col(keyed[32*c +: 32])
                                         : aesbc_pkg::mix_col(subbed[32*c +: 32]) ^
                                           rk[32*c +: 32];
      end
      if (cmd.load) begin
         s_in = {data_high, data_low} ^ rk;
      end else if (cmd.round) begin
         s_in = cmd.last ? keyed : mixed;
      end else begin
         s_in = s_ff;
      end
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in;
   end

   assign result_low  = s_ff[63:0];
   assign result_high = s_ff[127:64];

endmodule

// ----- src/aes_block_cipher_128_256_unit.sv -----
// Top level of the AES-128/AES-256 block cipher unit.
// One 128-bit block per item, encrypt (action 0) or decrypt (action 1) with the key in
// the key registers. An item is loaded, then runs one round at a time on the single
// shared round unit (10 rounds for AES-128, 14 for AES-256); the result is held until
// taken. After reset and after every key register write the key schedule runs one
// 32-bit word per cycle into the round key store, 44 words for AES-128 and 60 for
// AES-256; no item is taken meanwhile. Decryption is the straight inverse cipher on
// the same round keys.
module aes_block_cipher_128_256_unit (
   input  logic        clock,
   input  logic        reset,
   aesbc_req_if.sink   req,
   aesbc_rsp_if.source rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   aesbc_pkg::cmd_type    cmd;
   aesbc_pkg::status_type status;
   logic                  csr_wr;
   logic                  csr_hit;
   logic [2:0]            csr_idx;

   // 64-bit registers at 8-byte strides
   assign pready  = 1'b1;
   assign csr_idx = paddr[5:3];
   assign csr_wr  = psel && penable && pwrite;
   // writes past the last register are dropped and do not touch the keys
   assign csr_hit = csr_wr && (csr_idx <= 3'(aesbc_pkg::REG_KEY_WORD_3));

   aesbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg_write  (csr_hit),
      .req_valid  (req.valid),
      .req_action (req.action),
      .req_ready  (req.ready),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .status     (status),
      .cmd        (cmd)
   );

   aesbc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr      (csr_hit),
      .csr_idx     (csr_idx),
      .csr_wdata   (pwdata),
      .csr_rdata   (prdata),
      .cmd         (cmd),
      .status      (status),
      .data_low    (req.data_low),
      .data_high   (req.data_high),
      .result_low  (rsp.result_low),
      .result_high (rsp.result_high)
   );

endmodule
